FILE: src/bmpu_pkg.sv
// Shared types, constants and helper functions of the BMP bitfield pixel unpacker.
package bmpu_pkg;

    // Field widths.
    localparam int DATA_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int CHAN_W    = 8;
    localparam int BPP_W     = 3;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int CFG_IDX_W = 8;
    localparam int SHIFT_W   = 5;
    localparam int NUM_W     = DATA_W + CHAN_W;

    // Defaults of the top-level parameters.
    localparam int MAX_DIM_DEF     = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Largest dimension the 13-bit size registers can hold.
    localparam int DIM_REG_MAX = 8191;

    // Channel values for an empty mask.
    localparam logic [CHAN_W-1:0] CHAN_ZERO   = 8'd0;
    localparam logic [CHAN_W-1:0] CHAN_OPAQUE = 8'd255;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RED_MASK   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MASK = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BPP        = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN   = 8'd7;

    // Register reset values.
    localparam logic [DATA_W-1:0] RST_RED_MASK   = 32'h00FF_0000;
    localparam logic [DATA_W-1:0] RST_GREEN_MASK = 32'h0000_FF00;
    localparam logic [DATA_W-1:0] RST_BLUE_MASK  = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] RST_ALPHA_MASK = 32'h0000_0000;
    localparam logic [BPP_W-1:0]  RST_BPP        = 3'd4;
    localparam logic [DIM_W-1:0]  RST_WIDTH      = 13'd1;
    localparam logic [DIM_W-1:0]  RST_HEIGHT     = 13'd1;
    localparam logic              RST_TOP_DOWN   = 1'b0;

    // One assembled pixel with its destination, passed from front to back.
    typedef struct packed {
        logic [DATA_W-1:0]  word;
        logic [COORD_W-1:0] dest_row;
        logic [COORD_W-1:0] dest_column;
        logic               image_done;
    } t_pixel;

    // Sequencing strobes from the back controller to the channel lanes.
    typedef struct packed {
        logic load;
        logic mul;
        logic step;
    } t_lane_ctl;

    // Back-end controller states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_HOLD = 5'b10000
    } t_back_state;

    // Trailing-zero count of a mask: isolate the lowest set bit, then encode it.
    function automatic logic [SHIFT_W-1:0] mask_shift(input logic [DATA_W-1:0] mask);
        logic [DATA_W-1:0]  low;
        logic [SHIFT_W-1:0] sh;
        low = mask & (~mask + 32'd1);
        sh  = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (low[i]) begin
                sh = sh | SHIFT_W'(i);
            end
        end
        return sh;
    endfunction

endpackage

FILE: src/bmpu_front.sv
// Front end: gathers bytes into pixel words, drops row padding and tracks position.
module bmpu_front #(
    parameter int MAX_DIM = bmpu_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [bmpu_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [bmpu_pkg::BPP_W-1:0]    i_bpp,
    input  logic [bmpu_pkg::DIM_W-1:0]    i_width,
    input  logic [bmpu_pkg::DIM_W-1:0]    i_height,
    input  logic                          i_top_down,
    output logic                          o_q_push,
    output bmpu_pkg::t_pixel              o_q_pixel,
    input  logic                          i_q_full
);

    localparam int DIM_CAP = (MAX_DIM < bmpu_pkg::DIM_REG_MAX) ? MAX_DIM
                                                               : bmpu_pkg::DIM_REG_MAX;
    localparam int CNT_W   = $clog2(DIM_CAP);
    localparam int CMP_W   = bmpu_pkg::DIM_W + 1;

    logic [bmpu_pkg::DATA_W-1:0]  r_word;
    logic [1:0]                   r_byte_cnt;
    logic [CNT_W-1:0]             r_col;
    logic [CNT_W-1:0]             r_row;
    logic [1:0]                   r_pad;

    logic [bmpu_pkg::BPP_W-1:0]   w_bpp;
    logic [bmpu_pkg::DIM_W-1:0]   w_w;
    logic [bmpu_pkg::DIM_W-1:0]   w_h;
    logic                         w_is_pad;
    logic                         w_complete;
    logic                         w_accept;
    logic [bmpu_pkg::DATA_W-1:0]  w_word_new;
    logic                         w_row_end;
    logic                         w_last_row;
    logic [bmpu_pkg::DIM_W-1:0]   w_row_dst;
    logic [bmpu_pkg::DIM_W-1:0]   w_col_ext;
    logic [4:0]                   w_row_bytes;
    logic [1:0]                   w_pad_next;

    // Clamp the geometry registers into their legal ranges.
    always_comb begin
        if (i_bpp < 3'd2) begin
            w_bpp = 3'd2;
        end else if (i_bpp > 3'd4) begin
            w_bpp = 3'd4;
        end else begin
            w_bpp = i_bpp;
        end
        if (i_width == '0) begin
            w_w = 13'd1;
        end else if (32'(i_width) > 32'(DIM_CAP)) begin
            w_w = bmpu_pkg::DIM_W'(DIM_CAP);
        end else begin
            w_w = i_width;
        end
        if (i_height == '0) begin
            w_h = 13'd1;
        end else if (32'(i_height) > 32'(DIM_CAP)) begin
            w_h = bmpu_pkg::DIM_W'(DIM_CAP);
        end else begin
            w_h = i_height;
        end
    end

    // An item either is a pad byte, adds to the word, or completes a pixel.
    assign w_is_pad   = (r_pad != 2'd0);
    assign w_complete = !w_is_pad && (({1'b0, r_byte_cnt} + 3'd1) >= w_bpp);
    assign o_full     = w_complete && i_q_full;
    assign w_accept   = i_push && !o_full;
    assign w_word_new = r_word | (bmpu_pkg::DATA_W'(i_data_byte) << {r_byte_cnt, 3'b000});

    // Row and image boundaries, and the flipped destination row.
    assign w_row_end  = (CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(w_w);
    assign w_last_row = (CMP_W'(r_row) + CMP_W'(1)) >= CMP_W'(w_h);
    assign w_col_ext  = bmpu_pkg::DIM_W'(r_col);

    always_comb begin
        if (i_top_down) begin
            w_row_dst = bmpu_pkg::DIM_W'(r_row);
        end else if (CMP_W'(r_row) >= CMP_W'(w_h)) begin
            w_row_dst = '0;
        end else begin
            w_row_dst = w_h - 13'd1 - bmpu_pkg::DIM_W'(r_row);
        end
    end

    // Pad bytes fill the row up to a multiple of four bytes.
    assign w_row_bytes = 5'(w_w[1:0]) * 5'(w_bpp);
    assign w_pad_next  = 2'(2'd0 - w_row_bytes[1:0]);

    // Pixel toward the queue.
    assign o_q_push              = w_accept && w_complete;
    assign o_q_pixel.word        = w_word_new;
    assign o_q_pixel.dest_row    = w_row_dst[bmpu_pkg::COORD_W-1:0];
    assign o_q_pixel.dest_column = w_col_ext[bmpu_pkg::COORD_W-1:0];
    assign o_q_pixel.image_done  = w_row_end && w_last_row;

    // Byte gathering and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word     <= '0;
            r_byte_cnt <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_pad      <= '0;
        end else if (w_accept) begin
            if (w_is_pad) begin
                r_pad <= r_pad - 2'd1;
            end else if (!w_complete) begin
                r_word     <= w_word_new;
                r_byte_cnt <= r_byte_cnt + 2'd1;
            end else begin
                r_word     <= '0;
                r_byte_cnt <= '0;
                if (w_row_end) begin
                    r_col <= '0;
                    if (w_last_row) begin
                        r_row <= '0;
                        r_pad <= '0;
                    end else begin
                        r_row <= r_row + CNT_W'(1);
                        r_pad <= w_pad_next;
                    end
                end else begin
                    r_col <= r_col + CNT_W'(1);
                end
            end
        end
    end

endmodule

FILE: src/bmpu_queue.sv
// Short first-in first-out queue of pixels between the front and back ends.
module bmpu_queue #(
    parameter int DEPTH = bmpu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bmpu_pkg::t_pixel i_pixel,
    output logic             o_full,
    input  logic             i_pop,
    output bmpu_pkg::t_pixel o_head,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bmpu_pkg::t_pixel r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_pixel;
        end
    end

    // Pointers wrap at the depth, which need not be a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: src/bmpu_scale_lane.sv
// One color channel: extracts the field and scales it by 255/max with a restoring divider.
module bmpu_scale_lane (
    input  logic                          i_clk,
    input  bmpu_pkg::t_lane_ctl           i_ctl,
    input  logic [bmpu_pkg::DATA_W-1:0]   i_word,
    input  logic [bmpu_pkg::DATA_W-1:0]   i_mask,
    input  logic [bmpu_pkg::CHAN_W-1:0]   i_if_zero,
    output logic [bmpu_pkg::CHAN_W-1:0]   o_value
);

    logic                          r_zero;
    logic [bmpu_pkg::DATA_W-1:0]   r_max;
    logic [bmpu_pkg::DATA_W-1:0]   r_field;
    logic [bmpu_pkg::NUM_W-1:0]    r_rem;
    logic [bmpu_pkg::NUM_W-1:0]    r_div;
    logic [bmpu_pkg::CHAN_W-1:0]   r_quo;

    logic [bmpu_pkg::SHIFT_W-1:0]  w_sh;
    logic [bmpu_pkg::DATA_W-1:0]   w_max;
    logic                          w_ge;

    assign w_sh  = bmpu_pkg::mask_shift(i_mask);
    assign w_max = i_mask >> w_sh;
    assign w_ge  = (r_rem >= r_div);

    // Load the field, form field*255, then retire one quotient bit per step.
    // The field never exceeds max, so the quotient fits in eight bits.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_zero  <= (i_mask == '0);
            r_max   <= w_max;
            r_field <= (i_word >> w_sh) & w_max;
        end
        if (i_ctl.mul) begin
            r_rem <= {r_field, 8'h00} - bmpu_pkg::NUM_W'(r_field);
            r_div <= {1'b0, r_max, 7'h00};
        end
        if (i_ctl.step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
            r_quo <= {r_quo[bmpu_pkg::CHAN_W-2:0], w_ge};
        end
    end

    assign o_value = r_zero ? i_if_zero : r_quo;

endmodule

FILE: src/bmpu_back.sv
// Back end: takes pixels from the queue, scales the four channels and holds the result.
module bmpu_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  bmpu_pkg::t_pixel              i_q_head,
    input  logic [bmpu_pkg::DATA_W-1:0]   i_red_mask,
    input  logic [bmpu_pkg::DATA_W-1:0]   i_green_mask,
    input  logic [bmpu_pkg::DATA_W-1:0]   i_blue_mask,
    input  logic [bmpu_pkg::DATA_W-1:0]   i_alpha_mask,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [bmpu_pkg::CHAN_W-1:0]   o_red,
    output logic [bmpu_pkg::CHAN_W-1:0]   o_green,
    output logic [bmpu_pkg::CHAN_W-1:0]   o_blue,
    output logic [bmpu_pkg::CHAN_W-1:0]   o_alpha,
    output logic [bmpu_pkg::COORD_W-1:0]  o_dest_row,
    output logic [bmpu_pkg::COORD_W-1:0]  o_dest_column,
    output logic                          o_image_done
);

    localparam int STEP_W = $clog2(bmpu_pkg::CHAN_W);

    bmpu_pkg::t_back_state          r_state;
    bmpu_pkg::t_back_state          n_state;
    logic [STEP_W-1:0]              r_step;
    bmpu_pkg::t_pixel               r_pix;
    logic                           r_out_valid;
    logic [bmpu_pkg::CHAN_W-1:0]    r_red;
    logic [bmpu_pkg::CHAN_W-1:0]    r_green;
    logic [bmpu_pkg::CHAN_W-1:0]    r_blue;
    logic [bmpu_pkg::CHAN_W-1:0]    r_alpha;
    logic [bmpu_pkg::COORD_W-1:0]   r_dest_row;
    logic [bmpu_pkg::COORD_W-1:0]   r_dest_column;
    logic                           r_image_done;

    bmpu_pkg::t_lane_ctl            w_ctl;
    logic                           w_out_write;
    logic                           w_out_take;
    logic [bmpu_pkg::CHAN_W-1:0]    w_red;
    logic [bmpu_pkg::CHAN_W-1:0]    w_green;
    logic [bmpu_pkg::CHAN_W-1:0]    w_blue;
    logic [bmpu_pkg::CHAN_W-1:0]    w_alpha;

    assign w_out_take = i_pop && r_out_valid;

    // Sequencer: fetch, load, multiply, eight divide steps, hand to output.
    always_comb begin
        n_state     = r_state;
        w_ctl       = '0;
        o_q_pop     = 1'b0;
        w_out_write = 1'b0;
        case (r_state)
            bmpu_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = bmpu_pkg::S_LOAD;
                end
            end
            bmpu_pkg::S_LOAD: begin
                w_ctl.load = 1'b1;
                n_state    = bmpu_pkg::S_MUL;
            end
            bmpu_pkg::S_MUL: begin
                w_ctl.mul = 1'b1;
                n_state   = bmpu_pkg::S_DIV;
            end
            bmpu_pkg::S_DIV: begin
                w_ctl.step = 1'b1;
                if (r_step == STEP_W'(bmpu_pkg::CHAN_W - 1)) begin
                    n_state = bmpu_pkg::S_HOLD;
                end
            end
            bmpu_pkg::S_HOLD: begin
                if (!r_out_valid || w_out_take) begin
                    w_out_write = 1'b1;
                    n_state     = bmpu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmpu_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmpu_pkg::S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bmpu_pkg::S_MUL) begin
                r_step <= '0;
            end else if (w_ctl.step) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (w_out_write) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pix <= i_q_head;
        end
        if (w_out_write) begin
            r_red         <= w_red;
            r_green       <= w_green;
            r_blue        <= w_blue;
            r_alpha       <= w_alpha;
            r_dest_row    <= r_pix.dest_row;
            r_dest_column <= r_pix.dest_column;
            r_image_done  <= r_pix.image_done;
        end
    end

    // Four channel lanes run side by side.
    bmpu_scale_lane u_lane_red (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_word    (r_pix.word),
        .i_mask    (i_red_mask),
        .i_if_zero (bmpu_pkg::CHAN_ZERO),
        .o_value   (w_red)
    );

    bmpu_scale_lane u_lane_green (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_word    (r_pix.word),
        .i_mask    (i_green_mask),
        .i_if_zero (bmpu_pkg::CHAN_ZERO),
        .o_value   (w_green)
    );

    bmpu_scale_lane u_lane_blue (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_word    (r_pix.word),
        .i_mask    (i_blue_mask),
        .i_if_zero (bmpu_pkg::CHAN_ZERO),
        .o_value   (w_blue)
    );

    bmpu_scale_lane u_lane_alpha (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_word    (r_pix.word),
        .i_mask    (i_alpha_mask),
        .i_if_zero (bmpu_pkg::CHAN_OPAQUE),
        .o_value   (w_alpha)
    );

    assign o_empty       = !r_out_valid;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_alpha       = r_alpha;
    assign o_dest_row    = r_dest_row;
    assign o_dest_column = r_dest_column;
    assign o_image_done  = r_image_done;

endmodule

FILE: src/bmp_bitfield_pixel_unpacker.sv
// Top level: configuration registers, front end, pixel queue and back end.
// A completing byte is queued; the back end then fetches, loads, multiplies, divides and holds the result.
// Throughput: one byte per cycle while the 4-entry pixel queue has room; the back end fetches a new
// pixel only after the 8-step restoring divider that each channel lane runs and its hold are done.
// Pad bytes and non-final pixel bytes are taken every cycle without waiting on the back end.
// Reset (synchronous, active low) restores the register defaults and empties all stages.
module bmp_bitfield_pixel_unpacker #(
    parameter int MAX_DIM     = bmpu_pkg::MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = bmpu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [bmpu_pkg::BYTE_W-1:0]      i_data_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [bmpu_pkg::CHAN_W-1:0]      o_red,
    output logic [bmpu_pkg::CHAN_W-1:0]      o_green,
    output logic [bmpu_pkg::CHAN_W-1:0]      o_blue,
    output logic [bmpu_pkg::CHAN_W-1:0]      o_alpha,
    output logic [bmpu_pkg::COORD_W-1:0]     o_dest_row,
    output logic [bmpu_pkg::COORD_W-1:0]     o_dest_column,
    output logic                             o_image_done,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bmpu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bmpu_pkg::DATA_W-1:0]      i_cfg_data
);

    logic [bmpu_pkg::DATA_W-1:0]  r_red_mask;
    logic [bmpu_pkg::DATA_W-1:0]  r_green_mask;
    logic [bmpu_pkg::DATA_W-1:0]  r_blue_mask;
    logic [bmpu_pkg::DATA_W-1:0]  r_alpha_mask;
    logic [bmpu_pkg::BPP_W-1:0]   r_bpp;
    logic [bmpu_pkg::DIM_W-1:0]   r_width;
    logic [bmpu_pkg::DIM_W-1:0]   r_height;
    logic                         r_top_down;

    logic                         w_q_push;
    bmpu_pkg::t_pixel             w_q_pixel;
    logic                         w_q_full;
    logic                         w_q_pop;
    bmpu_pkg::t_pixel             w_q_head;
    logic                         w_q_empty;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_mask   <= bmpu_pkg::RST_RED_MASK;
            r_green_mask <= bmpu_pkg::RST_GREEN_MASK;
            r_blue_mask  <= bmpu_pkg::RST_BLUE_MASK;
            r_alpha_mask <= bmpu_pkg::RST_ALPHA_MASK;
            r_bpp        <= bmpu_pkg::RST_BPP;
            r_width      <= bmpu_pkg::RST_WIDTH;
            r_height     <= bmpu_pkg::RST_HEIGHT;
            r_top_down   <= bmpu_pkg::RST_TOP_DOWN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bmpu_pkg::REG_RED_MASK:   r_red_mask   <= i_cfg_data;
                bmpu_pkg::REG_GREEN_MASK: r_green_mask <= i_cfg_data;
                bmpu_pkg::REG_BLUE_MASK:  r_blue_mask  <= i_cfg_data;
                bmpu_pkg::REG_ALPHA_MASK: r_alpha_mask <= i_cfg_data;
                bmpu_pkg::REG_BPP:        r_bpp        <= i_cfg_data[bmpu_pkg::BPP_W-1:0];
                bmpu_pkg::REG_WIDTH:      r_width      <= i_cfg_data[bmpu_pkg::DIM_W-1:0];
                bmpu_pkg::REG_HEIGHT:     r_height     <= i_cfg_data[bmpu_pkg::DIM_W-1:0];
                bmpu_pkg::REG_TOP_DOWN:   r_top_down   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Byte assembly and position tracking.
    bmpu_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_data_byte (i_data_byte),
        .i_bpp       (r_bpp),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_top_down  (r_top_down),
        .o_q_push    (w_q_push),
        .o_q_pixel   (w_q_pixel),
        .i_q_full    (w_q_full)
    );

    // Pixel queue between the two ends.
    bmpu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_pixel (w_q_pixel),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_head  (w_q_head),
        .o_empty (w_q_empty)
    );

    // Channel scaling and result register.
    bmpu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .o_q_pop       (w_q_pop),
        .i_q_head      (w_q_head),
        .i_red_mask    (r_red_mask),
        .i_green_mask  (r_green_mask),
        .i_blue_mask   (r_blue_mask),
        .i_alpha_mask  (r_alpha_mask),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_dest_row    (o_dest_row),
        .o_dest_column (o_dest_column),
        .o_image_done  (o_image_done)
    );

endmodule

FILE: src/bmpu_checker.sv
// Port-level checker of the pixel unpacker and its bind to the top level.
module bmpu_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    input  logic                             full,
    input  logic [bmpu_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                             empty,
    input  logic                             pop,
    input  logic [bmpu_pkg::CHAN_W-1:0]      o_red,
    input  logic [bmpu_pkg::CHAN_W-1:0]      o_green,
    input  logic [bmpu_pkg::CHAN_W-1:0]      o_blue,
    input  logic [bmpu_pkg::CHAN_W-1:0]      o_alpha,
    input  logic [bmpu_pkg::COORD_W-1:0]     o_dest_row,
    input  logic [bmpu_pkg::COORD_W-1:0]     o_dest_column,
    input  logic                             o_image_done,
    input  logic                             i_cfg_valid,
    input  logic                             o_cfg_ready,
    input  logic [bmpu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bmpu_pkg::DATA_W-1:0]      i_cfg_data
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) $past(!i_rst_n) |-> empty)
        else $error("result shown right after reset");

    // Reset leaves the pixel queue with room.
    a_reset_not_full: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !full)
        else $error("input blocked right after reset");

    // A result needs the whole scaling pass, so empty falls only after reset has stayed released.
    a_no_early_result: assert property (@(posedge i_clk)
        $fell(empty) |-> ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)))
        else $error("result appeared too soon after reset");

    // A waiting result holds until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_alpha) && $stable(o_dest_row)
            && $stable(o_dest_column) && $stable(o_image_done)))
        else $error("waiting result changed before it was taken");

endmodule

bind bmp_bitfield_pixel_unpacker bmpu_checker u_bmpu_checker (.*);
